// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks an implication on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/aes_pkg.sv =====
package aes_pkg;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic [63:0] iv_high;
      logic [63:0] iv_low;
      logic        first_of_message;
      logic [4:0]  valid_bytes;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
      logic        status;
   } rsp_type;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_KEY_WORD0  = 3'd0;
   localparam logic [2:0] REG_KEY_WORD1  = 3'd1;
   localparam logic [2:0] REG_KEY_WORD2  = 3'd2;
   localparam logic [2:0] REG_KEY_WORD3  = 3'd3;
   localparam logic [2:0] REG_KEY_SIZE   = 3'd4;
   localparam logic [2:0] REG_DIRECTION  = 3'd5;
   localparam logic [2:0] REG_CHAIN_MODE = 3'd6;

   localparam logic [1:0] MODE_ECB = 2'd0;
   localparam logic [1:0] MODE_CBC = 2'd1;
   localparam logic [1:0] MODE_CTR = 2'd2;

   localparam int NUM_ROUND_KEYS = 15;
   localparam int RK_IDX_W = 4;

   // Command from the sequencer to the round unit.
   typedef struct packed {
      logic          load;     // load state with key added
      logic          round;    // run one round
      logic          last;     // final round (no column mixing)
      logic          encrypt;
   } rnd_ctl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   // Multiply by x in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Forward column mix of one 32-bit column, byte 0 in the high bits.
   function automatic logic [31:0] mix_fwd(input logic [31:0] col);
      logic [7:0] a0, a1, a2, a3;
      a0 = col[31:24]; a1 = col[23:16]; a2 = col[15:8]; a3 = col[7:0];
      mix_fwd = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                 a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                 a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                 xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   // Inverse column mix: a preprocessing step followed by the forward mix.
   function automatic logic [31:0] mix_inv(input logic [31:0] col);
      logic [7:0] a0, a1, a2, a3, u, v;
      a0 = col[31:24]; a1 = col[23:16]; a2 = col[15:8]; a3 = col[7:0];
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      mix_inv = mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
   endfunction

   // Byte substitution of one 32-bit word.
   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

// ===== rtl/core/aes_round.sv =====
module aes_round (
   input  logic                 clock,
   input  aes_pkg::rnd_ctl_type ctl,
   input  logic [127:0]         load_data,
   input  logic [127:0]         round_key,
   output logic [127:0]         state
);

   logic [127:0] state_ff;
   logic [127:0] state_in;
   logic [7:0]   s_bytes [16];
   logic [7:0]   t_bytes [16];
   logic [127:0] shifted;
   logic [127:0] mixed;
   logic [127:0] fwd_out;
   logic [127:0] inv_sub;
   logic [127:0] inv_out;

   // Byte view of the state, byte 0 at the top.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s_bytes[i] = state_ff[127 - 8 * i -: 8];
      end
   end

   // Forward round: substitute, shift rows, mix columns (not in the last round), add key.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t_bytes[r + 4 * c] = aes_pkg::SBOX[s_bytes[r + 4 * ((c + r) % 4)]];
         end
      end
      for (int i = 0; i < 16; i++) begin
         shifted[127 - 8 * i -: 8] = t_bytes[i];
      end
      for (int c = 0; c < 4; c++) begin
         mixed[127 - 32 * c -: 32] = aes_pkg::mix_fwd(shifted[127 - 32 * c -: 32]);
      end
      fwd_out = (ctl.last ? shifted : mixed) ^ round_key;
   end

   // Inverse round: shift rows back, substitute back, add key, unmix (not in the last round).
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            inv_sub[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] =
               aes_pkg::INV_SBOX[s_bytes[r + 4 * c]];
         end
      end
      inv_sub = inv_sub ^ round_key;
      for (int c = 0; c < 4; c++) begin
         inv_out[127 - 32 * c -: 32] = aes_pkg::mix_inv(inv_sub[127 - 32 * c -: 32]);
      end
      if (ctl.last) begin
         inv_out = inv_sub;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (ctl.load) begin
         state_in = load_data ^ round_key;
      end else if (ctl.round) begin
         state_in = ctl.encrypt ? fwd_out : inv_out;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign state = state_ff;

endmodule

// ===== rtl/core/aes_key_exp.sv =====
module aes_key_exp (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [255:0] key,
   input  logic [1:0]   key_size,
   input  logic [3:0]   rd_index,
   output logic [127:0] rd_key,
   output logic         busy
);

   // Key words are produced one per cycle; four make one round key.
   typedef enum logic [1:0] {KX_IDLE, KX_RUN} kx_state_type;

   kx_state_type state_ff, state_in;
   logic [5:0]   word_ff, word_in;
   logic [3:0]   nk_cnt_ff, nk_cnt_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  win_ff [8];
   logic [31:0]  win_in [8];
   logic [127:0] pend_ff, pend_in;
   logic [127:0] round_keys [aes_pkg::NUM_ROUND_KEYS];
   logic [127:0] rd_key_ff;
   logic [3:0]   nk;
   logic [2:0]   nk_top;
   logic [5:0]   total_words;
   logic [31:0]  new_word;
   logic [31:0]  tmp;
   logic         wr_en;

   assign nk = 4'd4 + {1'b0, key_size, 1'b0};
   assign nk_top = 3'(nk - 4'd1);
   // Four words per round key over Nr + 1 keys, Nr = nk + 6.
   assign total_words = {nk, 2'b00} + 6'd28;

   // Next schedule word from the sliding window of the last nk words.
   always_comb begin
      tmp = win_ff[nk_top];
      if (nk_cnt_ff == 4'd0) begin
         tmp = aes_pkg::sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && nk_cnt_ff == 4'd4) begin
         tmp = aes_pkg::sub_word(tmp);
      end
      new_word = win_ff[0] ^ tmp;
   end

   always_comb begin
      state_in  = state_ff;
      word_in   = word_ff;
      nk_cnt_in = nk_cnt_ff;
      rcon_in   = rcon_ff;
      pend_in   = pend_ff;
      wr_en     = 1'b0;
      for (int i = 0; i < 8; i++) begin
         win_in[i] = win_ff[i];
      end
      unique case (state_ff)
         KX_IDLE: begin
            if (start) begin
               state_in  = KX_RUN;
               for (int i = 0; i < 8; i++) begin
                  win_in[i] = key[255 - 32 * i -: 32];
               end
               word_in   = 6'd0;
               nk_cnt_in = 4'd0;
               rcon_in   = 8'h01;
            end
         end
         KX_RUN: begin
            // The first nk words come straight from the key.
            if (word_ff < {2'b00, nk}) begin
               pend_in = {pend_ff[95:0], win_ff[word_ff[2:0]]};
            end else begin
               pend_in = {pend_ff[95:0], new_word};
               for (int i = 0; i < 7; i++) begin
                  win_in[i] = win_ff[i + 1];
               end
               win_in[nk_top] = new_word;
               if (nk_cnt_ff == nk - 4'd1) begin
                  nk_cnt_in = 4'd0;
               end else begin
                  nk_cnt_in = nk_cnt_ff + 4'd1;
               end
               if (nk_cnt_ff == 4'd0) begin
                  rcon_in = aes_pkg::xtime(rcon_ff);
               end
            end
            wr_en   = (word_ff[1:0] == 2'd3);
            word_in = word_ff + 6'd1;
            if (word_ff == total_words - 6'd1) begin
               state_in = KX_IDLE;
            end
         end
         default: state_in = KX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KX_IDLE;
      end else begin
         state_ff <= state_in;
      end
      word_ff   <= word_in;
      nk_cnt_ff <= nk_cnt_in;
      rcon_ff   <= rcon_in;
      pend_ff   <= pend_in;
      for (int i = 0; i < 8; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   // Round key store, one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         round_keys[word_ff[5:2]] <= pend_in;
      end
      rd_key_ff <= round_keys[rd_index];
   end

   assign rd_key = rd_key_ff;
   assign busy   = (state_ff != KX_IDLE) || start;

endmodule

// ===== rtl/core/aes_block_cipher_cbc_ctr.sv =====
// AES block cipher with 128, 192 and 256-bit keys in ECB, CBC and CTR modes.
// Requests arrive on the req_ channel (valid/ready) and carry one 128-bit
// data block, the IV or initial counter, a first-of-message flag and a byte
// count. One response per request leaves on the rsp_ channel with the result
// block and a status bit (1 = refused; the block then returns zeros and keeps
// its chaining state). The user must write registers over the csr_ channel
// only while the block is idle; the block itself does not enforce this. A
// key or key size write forces the round keys to be expanded again before
// the next request, one 32-bit word per cycle. A request takes the key
// addition plus Nr rounds from a single shared round unit, with a round key
// read ahead of each round; Nr = 10, 12 or 14. Refused requests go from the
// check state straight to the response. The block takes one request at a
// time; req_ready is low from acceptance until the response has been taken,
// so a stalled receiver holds the response register and the block waits. A
// synchronous reset returns the state machine to idle, clears the chaining
// value and the key registers, and marks the schedule as not built.
`include "assert_macros.svh"

module aes_block_cipher_cbc_ctr (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  aes_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aes_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_KEYS, ST_KEY0, ST_LOAD, ST_RKEY, ST_ROUND, ST_RESP
   } st_type;

   st_type           state_ff, state_in;
   aes_pkg::req_type req_ff;
   logic [255:0]     key_ff;
   logic [1:0]       key_size_ff;
   logic             direction_ff;
   logic [1:0]       chain_mode_ff;
   logic             sched_valid_ff, sched_valid_in;
   logic [127:0]     chain_ff;
   logic [3:0]       rnd_ff, rnd_in;
   logic [3:0]       nr;
   aes_pkg::rsp_type rsp_ff, rsp_in;
   logic             kx_start;
   logic             kx_busy;
   logic [3:0]       rk_index;
   logic [127:0]     rk;
   aes_pkg::rnd_ctl_type ctl;
   logic [127:0]     load_data;
   logic [127:0]     cstate;
   logic [127:0]     data;
   logic [127:0]     iv;
   logic [127:0]     chain_eff;
   logic [127:0]     res;
   logic [127:0]     byte_mask;
   logic             refuse;
   logic             enc;

   assign nr   = 4'd10 + {1'b0, key_size_ff, 1'b0};
   assign enc  = direction_ff;
   assign data = {req_ff.block_high, req_ff.block_low};
   assign iv   = {req_ff.iv_high, req_ff.iv_low};
   assign chain_eff = (req_ff.first_of_message) ? iv : chain_ff;

   assign refuse = (key_size_ff == 2'd3) || (chain_mode_ff == 2'd3) ||
                   (req_ff.valid_bytes == 5'd0) || (req_ff.valid_bytes > 5'd16) ||
                   (chain_mode_ff == aes_pkg::MODE_CTR && !enc) ||
                   (chain_mode_ff != aes_pkg::MODE_CTR && req_ff.valid_bytes != 5'd16);

   // Input to the first key addition, by mode.
   always_comb begin
      case (chain_mode_ff)
         aes_pkg::MODE_CBC: load_data = enc ? (data ^ chain_eff) : data;
         aes_pkg::MODE_CTR: load_data = chain_eff;
         default:           load_data = data;
      endcase
   end

   // Bytes at positions valid_bytes and above are cleared.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         byte_mask[127 - 8 * i -: 8] = ({27'd0, req_ff.valid_bytes} > i) ? 8'hff : 8'h00;
      end
   end

   always_comb begin
      case (chain_mode_ff)
         aes_pkg::MODE_CBC: res = enc ? cstate : (cstate ^ chain_eff);
         aes_pkg::MODE_CTR: res = (cstate ^ data) & byte_mask;
         default:           res = cstate;
      endcase
   end

   // Round key index in use for the current step.
   assign rk_index = enc ? rnd_ff : (nr - rnd_ff);

   always_comb begin
      state_in       = state_ff;
      rnd_in         = rnd_ff;
      rsp_in         = rsp_ff;
      sched_valid_in = sched_valid_ff;
      kx_start       = 1'b0;
      ctl            = '0;
      ctl.encrypt    = enc;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            rnd_in = 4'd0;
            if (refuse) begin
               rsp_in   = '{result_high: 64'd0, result_low: 64'd0, status: 1'b1};
               state_in = ST_RESP;
            end else if (!sched_valid_ff) begin
               kx_start = 1'b1;
               state_in = ST_KEYS;
            end else begin
               state_in = ST_KEY0;
            end
         end
         ST_KEYS: begin
            if (!kx_busy) begin
               sched_valid_in = 1'b1;
               state_in       = ST_KEY0;
            end
         end
         ST_KEY0: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            ctl.load = 1'b1;
            rnd_in   = 4'd1;
            state_in = ST_RKEY;
         end
         ST_RKEY: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            ctl.round = 1'b1;
            ctl.last  = (rnd_ff == nr);
            rnd_in    = rnd_ff + 4'd1;
            if (rnd_ff == nr) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_RKEY;
            end
         end
         ST_RESP: begin
            // The response register is loaded on entry for a refusal and in the first cycle of this state otherwise.
            if (rsp_ready && !finish_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // A key or key size write calls for a fresh schedule.
      if (csr_valid && csr_ready) begin
         case (csr_index) inside
            aes_pkg::REG_KEY_WORD0, aes_pkg::REG_KEY_WORD1, aes_pkg::REG_KEY_WORD2,
            aes_pkg::REG_KEY_WORD3, aes_pkg::REG_KEY_SIZE: sched_valid_in = 1'b0;
            default: ;
         endcase
      end
   end

   // State and configuration registers, and the response and chain update once the final round has landed.
   logic finish_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sched_valid_ff <= 1'b0;
         finish_ff      <= 1'b0;
         chain_ff       <= '0;
         key_ff         <= '0;
         key_size_ff    <= 2'd0;
         direction_ff   <= 1'b1;
         chain_mode_ff  <= aes_pkg::MODE_ECB;
      end else begin
         state_ff       <= state_in;
         sched_valid_ff <= sched_valid_in;
         finish_ff      <= (state_ff == ST_ROUND) && (rnd_ff == nr);
         if (finish_ff) begin
            case (chain_mode_ff)
               aes_pkg::MODE_CBC: chain_ff <= enc ? cstate : data;
               aes_pkg::MODE_CTR: chain_ff <= chain_eff + 128'd1;
               default:           chain_ff <= chain_ff;
            endcase
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               aes_pkg::REG_KEY_WORD0:  key_ff[255:192] <= csr_wdata;
               aes_pkg::REG_KEY_WORD1:  key_ff[191:128] <= csr_wdata;
               aes_pkg::REG_KEY_WORD2:  key_ff[127:64]  <= csr_wdata;
               aes_pkg::REG_KEY_WORD3:  key_ff[63:0]    <= csr_wdata;
               aes_pkg::REG_KEY_SIZE:   key_size_ff     <= csr_wdata[1:0];
               aes_pkg::REG_DIRECTION:  direction_ff    <= csr_wdata[0];
               aes_pkg::REG_CHAIN_MODE: chain_mode_ff   <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
      rnd_ff <= rnd_in;
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff <= req_data;
      end
      if (finish_ff) begin
         rsp_ff <= '{result_high: res[127:64], result_low: res[63:0], status: 1'b0};
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP) && !finish_ff;
   assign rsp_data  = rsp_ff;

   aes_key_exp u_key_exp (
      .clock    (clock),
      .reset    (reset),
      .start    (kx_start),
      .key      (key_ff),
      .key_size (key_size_ff),
      .rd_index (rk_index),
      .rd_key   (rk),
      .busy     (kx_busy)
   );

   aes_round u_round (
      .clock     (clock),
      .ctl       (ctl),
      .load_data (load_data),
      .round_key (rk),
      .state     (cstate)
   );

   `ASSERT_CLK(a_rsp_only_in_resp, clock, reset, rsp_valid |-> state_ff == ST_RESP, "rsp_valid outside response state")
   `ASSERT_CLK(a_no_req_while_busy, clock, reset, state_ff != ST_IDLE |-> !req_ready, "req_ready while busy")
   `ASSERT_CLK(a_rounds_need_keys, clock, reset, state_ff == ST_ROUND |-> sched_valid_ff, "round without schedule")
   `ASSERT_CLK(a_round_bound, clock, reset, state_ff == ST_ROUND |-> rnd_ff <= nr, "round count overrun")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   aes_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   aes_pkg::rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1600;

   aes_block_cipher_cbc_ctr u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow of the configuration and cipher state.
   logic [63:0]  key_w [4];
   logic [1:0]   key_len;
   logic         encrypt_dir;
   logic [1:0]   chain_sel;
   logic [127:0] chain_reg;
   logic [7:0]   sched [240];
   int           num_rounds;

   aes_pkg::rsp_type expected_rsps [$];
   int      error_count;
   int      idle_cycles;
   logic    stall_long;
   logic [7:0] inv_box [256];

   // Directed table: request, key size, direction, mode, optional typed result.
   typedef struct {
      aes_pkg::req_type req;
      logic [1:0]  ksize;
      logic        dir;
      logic [1:0]  mode;
      logic        fixed;
      aes_pkg::rsp_type rsp;
   } vector_row_type;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] gmul2(input logic [7:0] a);
      gmul2 = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = gmul2(a);
      end
      gmul = r;
   endfunction

   function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
      byte_at = v[127 - 8 * i -: 8];
   endfunction

   // Expands the key shadow into the byte schedule.
   task automatic expand_schedule();
      logic [255:0] kb;
      logic [7:0] w [4];
      logic [7:0] t;
      logic [7:0] rc;
      int nk;
      kb = {key_w[0], key_w[1], key_w[2], key_w[3]};
      nk = 4 + 2 * key_len;
      num_rounds = nk + 6;
      rc = 8'h01;
      for (int i = 0; i < nk * 4; i++) sched[i] = kb[255 - 8 * i -: 8];
      for (int i = nk; i < 4 * (num_rounds + 1); i++) begin
         for (int j = 0; j < 4; j++) w[j] = sched[(i - 1) * 4 + j];
         if (i % nk == 0) begin
            t = w[0];
            w[0] = aes_pkg::SBOX[w[1]] ^ rc;
            w[1] = aes_pkg::SBOX[w[2]];
            w[2] = aes_pkg::SBOX[w[3]];
            w[3] = aes_pkg::SBOX[t];
            rc = gmul2(rc);
         end else if (nk == 8 && i % nk == 4) begin
            for (int j = 0; j < 4; j++) w[j] = aes_pkg::SBOX[w[j]];
         end
         for (int j = 0; j < 4; j++) sched[i * 4 + j] = sched[(i - nk) * 4 + j] ^ w[j];
      end
   endtask

   function automatic void mix_cols(inout logic [7:0] s [16], input logic [7:0] m [4]);
      logic [7:0] col [4];
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) col[k] = s[4 * c + k];
         for (int r = 0; r < 4; r++) begin
            s[4 * c + r] = 8'h00;
            for (int k = 0; k < 4; k++) s[4 * c + r] ^= gmul(col[k], m[(k - r + 4) & 3]);
         end
      end
   endfunction

   function automatic logic [127:0] run_cipher(input logic [127:0] din, input logic enc);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] fm [4];
      logic [7:0] rm [4];
      logic [127:0] v;
      fm = '{8'd2, 8'd3, 8'd1, 8'd1};
      rm = '{8'd14, 8'd11, 8'd13, 8'd9};
      for (int i = 0; i < 16; i++) s[i] = byte_at(din, i);
      if (enc) begin
         for (int i = 0; i < 16; i++) s[i] ^= sched[i];
         for (int rnd = 1; rnd <= num_rounds; rnd++) begin
            for (int i = 0; i < 16; i++) s[i] = aes_pkg::SBOX[s[i]];
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++) t[r + 4 * c] = s[r + 4 * ((c + r) & 3)];
            s = t;
            if (rnd != num_rounds) mix_cols(s, fm);
            for (int i = 0; i < 16; i++) s[i] ^= sched[rnd * 16 + i];
         end
      end else begin
         for (int i = 0; i < 16; i++) s[i] ^= sched[num_rounds * 16 + i];
         for (int rnd = num_rounds - 1; rnd >= 0; rnd--) begin
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++) t[r + 4 * ((c + r) & 3)] = s[r + 4 * c];
            for (int i = 0; i < 16; i++) s[i] = inv_box[t[i]];
            for (int i = 0; i < 16; i++) s[i] ^= sched[rnd * 16 + i];
            if (rnd != 0) mix_cols(s, rm);
         end
      end
      for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = s[i];
      run_cipher = v;
   endfunction

   // Predicts the response of one accepted request and updates the shadow state.
   task automatic predict_cipher(input aes_pkg::req_type rq);
      aes_pkg::rsp_type r;
      logic [127:0] data, res, ks, mask;
      int nb;
      r = '0;
      r.status = 1'b1;
      nb = rq.valid_bytes;
      if (!(nb == 0 || nb > 16 || (chain_sel == aes_pkg::MODE_CTR && !encrypt_dir)
            || (chain_sel != aes_pkg::MODE_CTR && nb != 16))) begin
         data = {rq.block_high, rq.block_low};
         if (chain_sel != aes_pkg::MODE_ECB && rq.first_of_message)
            chain_reg = {rq.iv_high, rq.iv_low};
         if (chain_sel == aes_pkg::MODE_ECB) begin
            res = run_cipher(data, encrypt_dir);
         end else if (chain_sel == aes_pkg::MODE_CBC) begin
            if (encrypt_dir) begin
               res = run_cipher(data ^ chain_reg, 1'b1);
               chain_reg = res;
            end else begin
               res = run_cipher(data, 1'b0) ^ chain_reg;
               chain_reg = data;
            end
         end else begin
            ks = run_cipher(chain_reg, 1'b1);
            mask = (nb == 16) ? '1 : ~({128{1'b1}} >> (8 * nb));
            res = (data ^ ks) & mask;
            chain_reg = chain_reg + 128'd1;
         end
         r.result_high = res[127:64];
         r.result_low = res[63:0];
         r.status = 1'b0;
      end
      expected_rsps.push_back(r);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      // Waiting for a fresh falling edge keeps the previous write's release apart from this one.
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         aes_pkg::REG_KEY_WORD0, aes_pkg::REG_KEY_WORD1,
         aes_pkg::REG_KEY_WORD2, aes_pkg::REG_KEY_WORD3: key_w[idx] = val;
         aes_pkg::REG_KEY_SIZE:   key_len = val[1:0];
         aes_pkg::REG_DIRECTION:  encrypt_dir = val[0];
         aes_pkg::REG_CHAIN_MODE: chain_sel = val[1:0];
         default: ;
      endcase
      if (idx <= aes_pkg::REG_KEY_SIZE && key_len <= 2'd2) expand_schedule();
   endtask

   // Waits until every response has arrived, plus the block's drain time.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Valid is left up after acceptance; the next request or wait_idle lowers it
   // or replaces the payload in the same falling edge.
   task automatic send_request(input aes_pkg::req_type rq);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_cipher(rq);
      @(negedge clock);
   endtask

   function automatic aes_pkg::req_type random_request(input logic [1:0] mode,
                                                       input logic first);
      aes_pkg::req_type rq;
      rq.block_high = {$urandom, $urandom};
      rq.block_low = {$urandom, $urandom};
      rq.iv_high = {$urandom, $urandom};
      rq.iv_low = {$urandom, $urandom};
      rq.first_of_message = first;
      if (mode == aes_pkg::MODE_CTR) rq.valid_bytes = ($urandom_range(0, 3) == 0) ?
            5'($urandom_range(1, 15)) : 5'd16;
      else rq.valid_bytes = 5'd16;
      // Occasional broken request with a random byte count.
      if ($urandom_range(0, 19) == 0) rq.valid_bytes = 5'($urandom_range(0, 31));
      random_request = rq;
   endfunction

   // Response checker.
   always @(posedge clock) begin
      aes_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.result_high !== e.result_high)
               begin $display("%0t: result_high expected %h actual %h", $time,
                              e.result_high, rsp_data.result_high); error_count++; end
            if (rsp_data.result_low !== e.result_low)
               begin $display("%0t: result_low expected %h actual %h", $time,
                              e.result_low, rsp_data.result_low); error_count++; end
            if (rsp_data.status !== e.status)
               begin $display("%0t: status expected %h actual %h", $time,
                              e.status, rsp_data.status); error_count++; end
         end
      end
   end

   // Receiver with random stalls and long hold-offs whenever stall_long is set.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_long) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            stall_long = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      vector_row_type rows [$];
      vector_row_type v;
      aes_pkg::req_type rq;
      aes_pkg::rsp_type refused;
      logic [1:0] mode;
      logic [63:0] ones;
      logic ok;
      int len;
      for (int i = 0; i < 256; i++) inv_box[aes_pkg::SBOX[i]] = 8'(i);
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = aes_pkg::REG_KEY_WORD0;
      csr_wdata = '0;
      error_count = 0;
      idle_cycles = 0;
      stall_long = 1'b0;
      for (int i = 0; i < 4; i++) key_w[i] = '0;
      key_len = 2'd0;
      encrypt_dir = 1'b1;
      chain_sel = aes_pkg::MODE_ECB;
      chain_reg = '0;
      expand_schedule();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: the FIPS-197 appendix C vectors, extremes and refusals.
      ones = '1;
      refused = '0;
      refused.status = 1'b1;
      v.fixed = 1'b0;
      v.rsp = '0;
      v.req = '0;
      v.req.valid_bytes = 5'd16;
      v.req.block_high = 64'h0011223344556677;
      v.req.block_low = 64'h8899aabbccddeeff;
      v.ksize = 2'd0; v.dir = 1'b1; v.mode = aes_pkg::MODE_ECB;
      rows.push_back(v);
      v.ksize = 2'd1; rows.push_back(v);
      v.ksize = 2'd2; rows.push_back(v);
      v.dir = 1'b0; rows.push_back(v);
      v.ksize = 2'd0; rows.push_back(v);
      v.req.block_high = ones; v.req.block_low = ones; v.dir = 1'b1; rows.push_back(v);
      v.req.block_high = '0; v.req.block_low = '0; rows.push_back(v);
      v.mode = aes_pkg::MODE_CBC; v.req.first_of_message = 1'b1;
      v.req.iv_high = ones; v.req.iv_low = ones; rows.push_back(v);
      v.req.first_of_message = 1'b0; rows.push_back(v);
      v.dir = 1'b0; v.req.first_of_message = 1'b1; rows.push_back(v);
      v.req.first_of_message = 1'b0; rows.push_back(v);
      v.mode = aes_pkg::MODE_CTR; v.dir = 1'b1; v.req.first_of_message = 1'b1;
      rows.push_back(v);
      v.req.first_of_message = 1'b0; v.req.valid_bytes = 5'd1; rows.push_back(v);
      v.req.valid_bytes = 5'd15; v.req.block_high = ones; rows.push_back(v);
      v.req.valid_bytes = 5'd16; v.ksize = 2'd2; rows.push_back(v);
      // Refused: CTR while decrypting, short blocks outside CTR, bad counts.
      v.fixed = 1'b1; v.rsp = refused;
      v.dir = 1'b0; rows.push_back(v);
      v.dir = 1'b1; v.req.valid_bytes = 5'd0; rows.push_back(v);
      v.req.valid_bytes = 5'd17; rows.push_back(v);
      v.req.valid_bytes = 5'd31; rows.push_back(v);
      v.mode = aes_pkg::MODE_ECB; v.req.valid_bytes = 5'd8; rows.push_back(v);
      v.mode = aes_pkg::MODE_CBC; v.req.valid_bytes = 5'd15; rows.push_back(v);
      v.fixed = 1'b0; v.mode = aes_pkg::MODE_CTR; v.req.valid_bytes = 5'd16;
      rows.push_back(v);

      csr_write(aes_pkg::REG_KEY_WORD0, 64'h0001020304050607);
      csr_write(aes_pkg::REG_KEY_WORD1, 64'h08090a0b0c0d0e0f);
      csr_write(aes_pkg::REG_KEY_WORD2, 64'h1011121314151617);
      csr_write(aes_pkg::REG_KEY_WORD3, 64'h18191a1b1c1d1e1f);
      foreach (rows[i]) begin
         if (rows[i].ksize != key_len || rows[i].dir != encrypt_dir
             || rows[i].mode != chain_sel) begin
            wait_idle();
            if (rows[i].ksize != key_len)
               csr_write(aes_pkg::REG_KEY_SIZE, 64'(rows[i].ksize));
            if (rows[i].dir != encrypt_dir)
               csr_write(aes_pkg::REG_DIRECTION, 64'(rows[i].dir));
            if (rows[i].mode != chain_sel)
               csr_write(aes_pkg::REG_CHAIN_MODE, 64'(rows[i].mode));
         end
         send_request(rows[i].req);
         // Typed results replace the predicted entry.
         if (rows[i].fixed) expected_rsps[expected_rsps.size() - 1] = rows[i].rsp;
      end
      wait_idle();

      // Random phases: new settings each phase and a new key in some, well-formed messages mostly.
      len = 0;
      stall_long = 1'b1;
      while (len < RANDOM_ITEMS) begin
         wait_idle();
         if ($urandom_range(0, 2) == 0) begin
            for (int k = 0; k < 4; k++)
               csr_write(3'(k), ($urandom_range(0, 7) == 0) ?
                         (($urandom_range(0, 1) == 0) ? 64'd0 : ones) : {$urandom, $urandom});
         end
         csr_write(aes_pkg::REG_KEY_SIZE, 64'($urandom_range(0, 2)));
         mode = 2'($urandom_range(0, 2));
         csr_write(aes_pkg::REG_CHAIN_MODE, 64'(mode));
         ok = (mode == aes_pkg::MODE_CTR) ? ($urandom_range(0, 9) != 0) :
              1'($urandom_range(0, 1));
         csr_write(aes_pkg::REG_DIRECTION, 64'(ok));
         if (len > RANDOM_ITEMS / 2 && $urandom_range(0, 9) == 0) stall_long = 1'b1;
         for (int n = $urandom_range(1, 40); n > 0; n--) begin
            rq = random_request(mode, (n % 13 == 0) || ($urandom_range(0, 15) == 0) || len == 0);
            send_request(rq);
            len++;
         end
      end
      wait_idle();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/aes_pkg.sv
rtl/core/aes_round.sv
rtl/core/aes_key_exp.sv
rtl/core/aes_block_cipher_cbc_ctr.sv
test/tb.sv
